/* rtl/sps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

    localparam int PAGE_BYTES   = 8192;
    localparam int HEADER_BYTES = 8;
    localparam int PTR_BYTES    = 2;

    localparam int ADDR_W   = $clog2(PAGE_BYTES);
    localparam int BOUND_W  = $clog2(PAGE_BYTES + 1);
    localparam int ALU_W    = 17;
    localparam int PTR_W    = 16;
    localparam int SIZE_W   = 14;
    localparam int CURSOR_W = 14;
    localparam int IDX_W    = 12;
    localparam int OFF_W    = 13;
    localparam int STATUS_W = 3;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [BOUND_W-1:0] bound_t;
    typedef logic [ALU_W-1:0]   alu_word_t;
    typedef logic [PTR_W-1:0]   ptr_t;

    localparam bound_t    PAGE_BOUND   = bound_t'(PAGE_BYTES);
    localparam bound_t    HEADER_BOUND = bound_t'(HEADER_BYTES);
    localparam alu_word_t PAGE_WORD    = alu_word_t'(PAGE_BYTES);
    localparam alu_word_t HEADER_WORD  = alu_word_t'(HEADER_BYTES);
    localparam alu_word_t PTR_WORD     = alu_word_t'(PTR_BYTES);
    localparam alu_word_t PREV_PTR_STEP = alu_word_t'(PTR_BYTES + 1);
    localparam alu_word_t ONE_WORD     = alu_word_t'(1);
    localparam logic [SIZE_W-1:0] FREE_MAX = SIZE_W'(PAGE_BYTES - HEADER_BYTES);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SLOT  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_OFF  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_STRAY    = 3'd4;

    localparam logic REG_MIN_FREE = 1'b0;
    localparam logic REG_LOCKED   = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SIZE_W-1:0] tuple_size;
        logic [7:0]        data_byte;
        logic [IDX_W-1:0]  tuple_index;
        logic [OFF_W-1:0]  byte_offset;
    } sps_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          read_byte;
        logic [SIZE_W-1:0]   tuple_length;
        logic                last_byte;
        logic [SIZE_W-1:0]   free_space;
    } sps_out_t;

    typedef struct packed {
        logic [SIZE_W-1:0] min_free;
        logic              locked;
    } cfg_t;

    typedef struct packed {
        alu_word_t a;
        alu_word_t b;
        logic      sub;
    } alu_req_t;

    typedef struct packed {
        alu_word_t sum;
        logic      borrow;
    } alu_res_t;

    typedef struct packed {
        logic       we;
        addr_t      addr;
        logic [7:0] wdata;
    } mem_req_t;

endpackage

`default_nettype wire

/* rtl/sps_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

module sps_alu (
    input  sps_pkg::alu_req_t req,
    output sps_pkg::alu_res_t res
);

    logic [sps_pkg::ALU_W:0] wide;

    assign wide = {1'b0, req.a} + {1'b0, req.b ^ {sps_pkg::ALU_W{req.sub}}}
                + {{sps_pkg::ALU_W{1'b0}}, req.sub};

    assign res.sum    = wide[sps_pkg::ALU_W-1:0];
    assign res.borrow = req.sub & ~wide[sps_pkg::ALU_W];

endmodule

`default_nettype wire

/* rtl/sps_page_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module sps_page_mem (
    input  wire               clk,
    input  sps_pkg::mem_req_t req,
    output logic [7:0]        rdata
);

    logic [7:0] page_reg [sps_pkg::PAGE_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            page_reg[req.addr] <= req.wdata;
        end
        rdata_reg <= page_reg[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/sps_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module sps_seq (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               req_valid,
    input  sps_pkg::sps_in_t  req_data,
    output logic              busy,
    input  sps_pkg::cfg_t     cfg,
    input  wire               res_ready,
    output logic              res_valid,
    output sps_pkg::sps_out_t res_data,
    output sps_pkg::alu_req_t alu_req,
    input  sps_pkg::alu_res_t alu_res,
    output sps_pkg::mem_req_t mem_req,
    input  wire [7:0]         mem_rdata
);

    typedef enum logic [23:0] {
        S_IDLE     = 24'h000001,
        S_INS_FREE = 24'h000002,
        S_INS_USED = 24'h000004,
        S_INS_FIT  = 24'h000008,
        S_INS_MIN  = 24'h000010,
        S_INS_PTR  = 24'h000020,
        S_INS_WLO  = 24'h000040,
        S_INS_WHI  = 24'h000080,
        S_DAT_WR   = 24'h000100,
        S_DAT_DEC  = 24'h000200,
        S_RD_SLOT  = 24'h000400,
        S_RD_CNT   = 24'h000800,
        S_RD_P0    = 24'h001000,
        S_RD_P1    = 24'h002000,
        S_RD_P2    = 24'h004000,
        S_RD_P3    = 24'h008000,
        S_RD_P4    = 24'h010000,
        S_RD_LEN   = 24'h020000,
        S_RD_OFF   = 24'h040000,
        S_RD_ADDR  = 24'h080000,
        S_RD_MEM   = 24'h100000,
        S_RD_BYTE  = 24'h200000,
        S_CLR      = 24'h400000,
        S_FIN      = 24'h800000
    } state_t;

    state_t                          state_reg, state_next;
    sps_pkg::bound_t                 lower_reg, lower_next;
    sps_pkg::bound_t                 upper_reg, upper_next;
    sps_pkg::bound_t                 cursor_reg, cursor_next;
    logic [sps_pkg::SIZE_W-1:0]      remaining_reg, remaining_next;
    sps_pkg::sps_in_t                item_reg, item_next;
    sps_pkg::alu_word_t              acc_reg, acc_next;
    sps_pkg::alu_word_t              aux_reg, aux_next;
    sps_pkg::ptr_t                   start_reg, start_next;
    sps_pkg::ptr_t                   end_reg, end_next;
    sps_pkg::ptr_t                   len_reg, len_next;
    logic [sps_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [7:0]                      rbyte_reg, rbyte_next;
    logic [sps_pkg::SIZE_W-1:0]      tlen_reg, tlen_next;
    logic                            last_reg, last_next;
    logic                            byte_ok_reg, byte_ok_next;
    sps_pkg::ptr_t                   upper_ptr;

    assign upper_ptr = sps_pkg::ptr_t'(upper_reg);

    always_comb
    begin
        state_next     = state_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        cursor_next    = cursor_reg;
        remaining_next = remaining_reg;
        item_next      = item_reg;
        acc_next       = acc_reg;
        aux_next       = aux_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        len_next       = len_reg;
        status_next    = status_reg;
        rbyte_next     = rbyte_reg;
        tlen_next      = tlen_reg;
        last_next      = last_reg;
        byte_ok_next   = byte_ok_reg;
        alu_req.a      = '0;
        alu_req.b      = '0;
        alu_req.sub    = 1'b0;
        mem_req.we     = 1'b0;
        mem_req.addr   = '0;
        mem_req.wdata  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next   = req_data;
                    status_next = sps_pkg::STATUS_OK;
                    rbyte_next  = '0;
                    tlen_next   = '0;
                    last_next   = 1'b0;
                    case (req_data.kind)
                        sps_pkg::KIND_INSERT: state_next = S_INS_FREE;
                        sps_pkg::KIND_DATA:   state_next = S_DAT_WR;
                        sps_pkg::KIND_READ:   state_next = S_RD_SLOT;
                        default:              state_next = S_CLR;
                    endcase
                end
            end
            S_INS_FREE:
            begin
                alu_req.a   = sps_pkg::alu_word_t'(upper_reg);
                alu_req.b   = sps_pkg::alu_word_t'(lower_reg);
                alu_req.sub = 1'b1;
                acc_next    = alu_res.sum;
                state_next  = S_INS_USED;
            end
            S_INS_USED:
            begin
                alu_req.a  = sps_pkg::alu_word_t'(item_reg.tuple_size);
                alu_req.b  = sps_pkg::PTR_WORD;
                aux_next   = alu_res.sum;
                state_next = S_INS_FIT;
            end
            S_INS_FIT:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = aux_reg;
                alu_req.sub = 1'b1;
                acc_next    = alu_res.sum;
                if (alu_res.borrow)
                begin
                    status_next = sps_pkg::STATUS_NO_FIT;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_INS_MIN;
                end
            end
            S_INS_MIN:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = sps_pkg::alu_word_t'(cfg.min_free);
                alu_req.sub = 1'b1;
                if (alu_res.borrow || cfg.locked)
                begin
                    status_next = sps_pkg::STATUS_NO_FIT;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_INS_PTR;
                end
            end
            S_INS_PTR:
            begin
                alu_req.a      = sps_pkg::alu_word_t'(upper_reg);
                alu_req.b      = sps_pkg::alu_word_t'(item_reg.tuple_size);
                alu_req.sub    = 1'b1;
                upper_next     = sps_pkg::bound_t'(alu_res.sum);
                cursor_next    = sps_pkg::bound_t'(alu_res.sum);
                remaining_next = item_reg.tuple_size;
                state_next     = S_INS_WLO;
            end
            S_INS_WLO:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = sps_pkg::addr_t'(lower_reg);
                mem_req.wdata = upper_ptr[7:0];
                alu_req.a     = sps_pkg::alu_word_t'(lower_reg);
                alu_req.b     = sps_pkg::ONE_WORD;
                acc_next      = alu_res.sum;
                state_next    = S_INS_WHI;
            end
            S_INS_WHI:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = sps_pkg::addr_t'(acc_reg);
                mem_req.wdata = upper_ptr[15:8];
                alu_req.a     = sps_pkg::alu_word_t'(lower_reg);
                alu_req.b     = sps_pkg::PTR_WORD;
                lower_next    = sps_pkg::bound_t'(alu_res.sum);
                state_next    = S_FIN;
            end
            S_DAT_WR:
            begin
                if (remaining_reg == '0)
                begin
                    status_next = sps_pkg::STATUS_STRAY;
                    state_next  = S_FIN;
                end
                else
                begin
                    mem_req.we    = (cursor_reg < sps_pkg::PAGE_BOUND);
                    mem_req.addr  = sps_pkg::addr_t'(cursor_reg);
                    mem_req.wdata = item_reg.data_byte;
                    alu_req.a     = sps_pkg::alu_word_t'(cursor_reg);
                    alu_req.b     = sps_pkg::ONE_WORD;
                    cursor_next   = sps_pkg::bound_t'(alu_res.sum[sps_pkg::CURSOR_W-1:0]);
                    state_next    = S_DAT_DEC;
                end
            end
            S_DAT_DEC:
            begin
                alu_req.a      = sps_pkg::alu_word_t'(remaining_reg);
                alu_req.b      = sps_pkg::ONE_WORD;
                alu_req.sub    = 1'b1;
                remaining_next = alu_res.sum[sps_pkg::SIZE_W-1:0];
                state_next     = S_FIN;
            end
            S_RD_SLOT:
            begin
                alu_req.a  = sps_pkg::HEADER_WORD;
                alu_req.b  = sps_pkg::alu_word_t'({item_reg.tuple_index, 1'b0});
                acc_next   = alu_res.sum;
                state_next = S_RD_CNT;
            end
            S_RD_CNT:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = sps_pkg::alu_word_t'(lower_reg);
                alu_req.sub = 1'b1;
                if (!alu_res.borrow)
                begin
                    status_next = sps_pkg::STATUS_NO_SLOT;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_RD_P0;
                end
            end
            S_RD_P0:
            begin
                mem_req.addr = sps_pkg::addr_t'(acc_reg);
                alu_req.a    = acc_reg;
                alu_req.b    = sps_pkg::ONE_WORD;
                acc_next     = alu_res.sum;
                state_next   = S_RD_P1;
            end
            S_RD_P1:
            begin
                mem_req.addr    = sps_pkg::addr_t'(acc_reg);
                start_next[7:0] = mem_rdata;
                alu_req.a       = acc_reg;
                alu_req.b       = sps_pkg::PREV_PTR_STEP;
                alu_req.sub     = 1'b1;
                acc_next        = alu_res.sum;
                state_next      = S_RD_P2;
            end
            S_RD_P2:
            begin
                start_next[15:8] = mem_rdata;
                if (item_reg.tuple_index == '0)
                begin
                    end_next   = sps_pkg::ptr_t'(sps_pkg::PAGE_BYTES);
                    state_next = S_RD_LEN;
                end
                else
                begin
                    mem_req.addr = sps_pkg::addr_t'(acc_reg);
                    alu_req.a    = acc_reg;
                    alu_req.b    = sps_pkg::ONE_WORD;
                    acc_next     = alu_res.sum;
                    state_next   = S_RD_P3;
                end
            end
            S_RD_P3:
            begin
                mem_req.addr  = sps_pkg::addr_t'(acc_reg);
                end_next[7:0] = mem_rdata;
                state_next    = S_RD_P4;
            end
            S_RD_P4:
            begin
                end_next[15:8] = mem_rdata;
                state_next     = S_RD_LEN;
            end
            S_RD_LEN:
            begin
                alu_req.a   = sps_pkg::alu_word_t'(end_reg);
                alu_req.b   = sps_pkg::alu_word_t'(start_reg);
                alu_req.sub = 1'b1;
                len_next    = alu_res.sum[sps_pkg::PTR_W-1:0];
                tlen_next   = alu_res.sum[sps_pkg::SIZE_W-1:0];
                state_next  = S_RD_OFF;
            end
            S_RD_OFF:
            begin
                alu_req.a   = sps_pkg::alu_word_t'(item_reg.byte_offset);
                alu_req.b   = sps_pkg::alu_word_t'(len_reg);
                alu_req.sub = 1'b1;
                if (!alu_res.borrow)
                begin
                    status_next = sps_pkg::STATUS_BAD_OFF;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_RD_ADDR;
                end
            end
            S_RD_ADDR:
            begin
                alu_req.a  = sps_pkg::alu_word_t'(start_reg);
                alu_req.b  = sps_pkg::alu_word_t'(item_reg.byte_offset);
                acc_next   = alu_res.sum;
                state_next = S_RD_MEM;
            end
            S_RD_MEM:
            begin
                mem_req.addr = sps_pkg::addr_t'(acc_reg);
                byte_ok_next = (acc_reg < sps_pkg::PAGE_WORD);
                alu_req.a    = sps_pkg::alu_word_t'(item_reg.byte_offset);
                alu_req.b    = sps_pkg::ONE_WORD;
                acc_next     = alu_res.sum;
                state_next   = S_RD_BYTE;
            end
            S_RD_BYTE:
            begin
                rbyte_next = byte_ok_reg ? mem_rdata : 8'd0;
                last_next  = (acc_reg == sps_pkg::alu_word_t'(len_reg));
                state_next = S_FIN;
            end
            S_CLR:
            begin
                lower_next     = sps_pkg::HEADER_BOUND;
                upper_next     = sps_pkg::PAGE_BOUND;
                cursor_next    = '0;
                remaining_next = '0;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                alu_req.a   = sps_pkg::alu_word_t'(upper_reg);
                alu_req.b   = sps_pkg::alu_word_t'(lower_reg);
                alu_req.sub = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lower_reg     <= sps_pkg::HEADER_BOUND;
            upper_reg     <= sps_pkg::PAGE_BOUND;
            cursor_reg    <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            cursor_reg    <= cursor_next;
            remaining_reg <= remaining_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        acc_reg     <= acc_next;
        aux_reg     <= aux_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        len_reg     <= len_next;
        status_reg  <= status_next;
        rbyte_reg   <= rbyte_next;
        tlen_reg    <= tlen_next;
        last_reg    <= last_next;
        byte_ok_reg <= byte_ok_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_FIN);

    always_comb
    begin
        res_data.status       = status_reg;
        res_data.read_byte    = rbyte_reg;
        res_data.tuple_length = tlen_reg;
        res_data.last_byte    = last_reg;
        res_data.free_space   = alu_res.sum[sps_pkg::SIZE_W-1:0];
    end

endmodule

`default_nettype wire

/* rtl/slotted_page_store_unit.sv */
// The block takes no new item while one is in progress; the next item is taken in the cycle
// after the result is loaded into the output register, while that result may still wait.
// The single adder and the one-port page memory set this one-at-a-time flow.
// Reset clears the bounds, pending byte count and configuration registers.
// Page memory contents are not cleared by reset or by a clear item.
`timescale 1ns / 1ps
`default_nettype none

module slotted_page_store_unit (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               req_valid,
    output logic              req_stall,
    input  sps_pkg::sps_in_t  req_data,
    output logic              rsp_valid,
    input  wire               rsp_stall,
    output sps_pkg::sps_out_t rsp_data,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [2:0]         paddr,
    input  wire [31:0]        pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [sps_pkg::SIZE_W-1:0] min_free_reg;
    logic                       locked_reg;
    logic                       rsp_valid_reg, rsp_valid_next;
    sps_pkg::sps_out_t          rsp_data_reg;
    sps_pkg::cfg_t              cfg;
    sps_pkg::alu_req_t          alu_req;
    sps_pkg::alu_res_t          alu_res;
    sps_pkg::mem_req_t          mem_req;
    logic [7:0]                 mem_rdata;
    logic                       busy;
    logic                       res_ready;
    logic                       res_valid;
    sps_pkg::sps_out_t          res_data;
    logic                       cfg_write;
    logic                       take;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_free_reg <= '0;
            locked_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                sps_pkg::REG_MIN_FREE: min_free_reg <= pwdata[sps_pkg::SIZE_W-1:0];
                default:               locked_reg   <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            sps_pkg::REG_MIN_FREE: prdata = 32'(min_free_reg);
            default:               prdata = 32'(locked_reg);
        endcase
    end

    assign cfg.min_free = min_free_reg;
    assign cfg.locked   = locked_reg;

    sps_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    sps_page_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    sps_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_data  (req_data),
        .busy      (busy),
        .cfg       (cfg),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_data  (res_data),
        .alu_req   (alu_req),
        .alu_res   (alu_res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    assign req_stall = busy;
    assign res_ready = !rsp_valid_reg || !rsp_stall;
    assign take      = res_valid && res_ready;

    always_comb
    begin
        if (take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_data_reg <= res_data;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("block took a new transfer without going busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.last_byte |-> rsp_data.status == sps_pkg::STATUS_OK)
        else $error("last byte flagged on a failed item");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.free_space <= sps_pkg::FREE_MAX)
        else $error("free space exceeds the usable page");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != sps_pkg::STATUS_OK |-> rsp_data.read_byte == 8'd0)
        else $error("read byte returned with an error status");

endmodule

`default_nettype wire
